// File: hdl/grey_block_average_quantizer_top_defines.svh
// Assertion macros shared by the grey block average quantizer modules.
`ifndef GREY_BLOCK_AVERAGE_QUANTIZER_TOP_DEFINES_SVH
`define GREY_BLOCK_AVERAGE_QUANTIZER_TOP_DEFINES_SVH

// The expression must hold at every clock edge outside reset.
`define GBAQ_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define GBAQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: hdl/gbaq_pkg.sv
// Types, constants and codes shared by the grey block average quantizer.
package gbaq_pkg;

   localparam int DIM_W      = 13;
   localparam int BLK_W      = 7;
   localparam int SUM_W      = 22;
   localparam int CNT_W      = 14;
   localparam int COORD_W    = 12;
   localparam int DIV_STEPS  = SUM_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam int DEF_MAX_WIDTH = 4096;
   localparam int DEF_MAX_BLOCK = 64;
   localparam int HEIGHT_LIMIT  = 4096;

   localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
   localparam logic [BLK_W-1:0] RST_TILE_WIDTH   = 7'd3;
   localparam logic [BLK_W-1:0] RST_TILE_HEIGHT  = 7'd5;
   localparam logic [7:0]       RST_PALETTE_TOP  = 8'd9;

   // floor(s / 100) for s below 25501 equals (s * 5243) >> 19.
   localparam logic [12:0] GREY_RECIP = 13'd5243;
   localparam int          GREY_SHIFT = 19;

   // floor((2*m*t + 255) / 510) equals floor((m*t + 127) / 255), and for values
   // up to 65152 that equals (v * 65794) >> 24.
   localparam logic [7:0]  IDX_BIAS  = 8'd127;
   localparam logic [16:0] IDX_RECIP = 17'd65794;
   localparam int          IDX_SHIFT = 24;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_TILE_WIDTH   = 3'd2,
      REG_TILE_HEIGHT  = 3'd3,
      REG_PALETTE_TOP  = 3'd4
   } reg_index_type;

   typedef enum logic {
      F_IDLE,
      F_UPDATE
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SIZE,
      B_DIV,
      B_SCALE,
      B_RESULT
   } back_state_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [BLK_W-1:0]   span_w;
      logic [BLK_W-1:0]   span_h;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               row_end;
      logic               image_end;
   } task_type;

endpackage

// File: hdl/grey_block_average_quantizer_top.sv
// Top level of the grey block average quantizer with its configuration registers.
// Pixels arrive in raster order; for each accepted beat the front end converts it to
// grey and reads the running block sum, then writes the sum back in its update state,
// and it takes no new pixel until that update retires. A finished block is handed
// through a two-entry queue to the back end, whose serial divider forms the mean; the
// scale state then forms the rounded palette product, which a reciprocal multiply
// turns into the index. The back end takes a new block only once the previous result
// has been loaded into the response registers. The front end stalls only when a block
// finishes while the queue is full. Any write to a known configuration register
// restarts the image at its first pixel.
module grey_block_average_quantizer_top import gbaq_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [DIM_W-1:0]   csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_mean_grey,
   output logic [7:0]         rsp_palette_index,
   output logic [COORD_W-1:0] rsp_block_column,
   output logic [COORD_W-1:0] rsp_block_row,
   output logic               rsp_row_end,
   output logic               rsp_image_end
);

   logic [DIM_W-1:0] image_width_ff, image_height_ff;
   logic [BLK_W-1:0] tile_width_ff, tile_height_ff;
   logic [7:0]       palette_top_ff;
   logic [DIM_W-1:0] width_in, height_in;
   logic [BLK_W-1:0] bsize_in;
   logic             known_index;

   logic     push, full, pop, not_empty;
   task_type push_task, head;

   // Zero sizes act as one and oversized ones saturate; tile sizes are first cut to their low BLK_W bits.
   always_comb begin
      width_in  = csr_wdata;
      height_in = csr_wdata;
      bsize_in  = csr_wdata[BLK_W-1:0];
      if (csr_wdata == '0) begin
         width_in  = DIM_W'(1);
         height_in = DIM_W'(1);
      end else begin
         if (32'(csr_wdata) > MAX_WIDTH) begin
            width_in = DIM_W'(MAX_WIDTH);
         end
         if (32'(csr_wdata) > HEIGHT_LIMIT) begin
            height_in = DIM_W'(HEIGHT_LIMIT);
         end
      end
      if (csr_wdata[BLK_W-1:0] == '0) begin
         bsize_in = BLK_W'(1);
      end else if (32'(csr_wdata[BLK_W-1:0]) > MAX_BLOCK) begin
         bsize_in = BLK_W'(MAX_BLOCK);
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_TILE_WIDTH, REG_TILE_HEIGHT,
         REG_PALETTE_TOP: known_index = 1'b1;
         default:         known_index = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RST_IMAGE_WIDTH;
         image_height_ff <= RST_IMAGE_HEIGHT;
         tile_width_ff   <= RST_TILE_WIDTH;
         tile_height_ff  <= RST_TILE_HEIGHT;
         palette_top_ff  <= RST_PALETTE_TOP;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= width_in;
            REG_IMAGE_HEIGHT: image_height_ff <= height_in;
            REG_TILE_WIDTH:   tile_width_ff   <= bsize_in;
            REG_TILE_HEIGHT:  tile_height_ff  <= bsize_in;
            REG_PALETTE_TOP:  palette_top_ff  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   gbaq_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .clear        (csr_we && known_index),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .tile_width   (tile_width_ff),
      .tile_height  (tile_height_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .push         (push),
      .push_task    (push_task),
      .queue_full   (full)
   );

   gbaq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   gbaq_back u_back (
      .clock             (clock),
      .reset             (reset),
      .palette_top       (palette_top_ff),
      .q_not_empty       (not_empty),
      .q_head            (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mean_grey     (rsp_mean_grey),
      .rsp_palette_index (rsp_palette_index),
      .rsp_block_column  (rsp_block_column),
      .rsp_block_row     (rsp_block_row),
      .rsp_row_end       (rsp_row_end),
      .rsp_image_end     (rsp_image_end)
   );

endmodule

// File: hdl/gbaq_front.sv
// Front end: grey conversion, raster position tracking and per-band block sums.
module gbaq_front import gbaq_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic [DIM_W-1:0] image_width,
   input  logic [DIM_W-1:0] image_height,
   input  logic [BLK_W-1:0] tile_width,
   input  logic [BLK_W-1:0] tile_height,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_red,
   input  logic [7:0]       req_green,
   input  logic [7:0]       req_blue,
   output logic             push,
   output task_type         push_task,
   input  logic             queue_full
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);

   front_state_type state_ff, state_in;
   logic [7:0]       grey_ff;
   logic [DIM_W-1:0] pix_col_ff, pix_col_in;
   logic [DIM_W-1:0] pix_row_ff, pix_row_in;
   logic [BLK_W-1:0] cib_ff, cib_in;
   logic [BLK_W-1:0] rib_ff, rib_in;
   logic [DIM_W-1:0] bcol_ff, bcol_in;
   logic [DIM_W-1:0] brow_ff, brow_in;
   logic [SUM_W-1:0] rd_ff;
   logic [SUM_W-1:0] sums [MAX_WIDTH];

   logic [14:0]       weighted;
   logic [27:0]       scaled;
   logic [ADDR_W-1:0] slot;
   logic              last_col, last_row, x_end, y_end, first;
   logic [SUM_W-1:0]  sum_new;
   logic [DIM_W-1:0]  start_col, start_row, left_w, left_h;
   logic [BLK_W-1:0]  span_w, span_h;
   logic              accept, advance;

   assign weighted = 15'(30 * req_red) + 15'(59 * req_green) + 15'(11 * req_blue);
   assign scaled   = 28'(weighted) * 28'(GREY_RECIP);
   assign slot     = ADDR_W'(bcol_ff);

   assign last_col = ({1'b0, pix_col_ff} + 14'd1) >= {1'b0, image_width};
   assign last_row = ({1'b0, pix_row_ff} + 14'd1) >= {1'b0, image_height};
   assign x_end    = last_col || (({1'b0, cib_ff} + 8'd1) >= {1'b0, tile_width});
   assign y_end    = last_row || (({1'b0, rib_ff} + 8'd1) >= {1'b0, tile_height});
   assign first    = (cib_ff == '0) && (rib_ff == '0);
   assign sum_new  = first ? SUM_W'(grey_ff) : rd_ff + SUM_W'(grey_ff);

   // Partial blocks at the right and bottom edges are cut to the image.
   assign start_col = pix_col_ff - DIM_W'(cib_ff);
   assign start_row = pix_row_ff - DIM_W'(rib_ff);
   assign left_w    = image_width - start_col;
   assign left_h    = image_height - start_row;
   assign span_w    = (DIM_W'(tile_width) < left_w) ? tile_width : left_w[BLK_W-1:0];
   assign span_h    = (DIM_W'(tile_height) < left_h) ? tile_height : left_h[BLK_W-1:0];

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      accept     = 1'b0;
      advance    = 1'b0;
      push       = 1'b0;
      pix_col_in = pix_col_ff;
      pix_row_in = pix_row_ff;
      cib_in     = cib_ff;
      rib_in     = rib_ff;
      bcol_in    = bcol_ff;
      brow_in    = brow_ff;
      unique case (state_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (req_valid) begin
               state_in = F_UPDATE;
            end
         end
         F_UPDATE: begin
            advance = !(x_end && y_end) || !queue_full;
            push    = advance && x_end && y_end;
            if (advance) begin
               state_in = F_IDLE;
               if (last_col) begin
                  pix_col_in = '0;
                  cib_in     = '0;
                  bcol_in    = '0;
                  if (last_row) begin
                     pix_row_in = '0;
                     rib_in     = '0;
                     brow_in    = '0;
                  end else begin
                     pix_row_in = pix_row_ff + 1'b1;
                     if (y_end) begin
                        rib_in  = '0;
                        brow_in = brow_ff + 1'b1;
                     end else begin
                        rib_in = rib_ff + 1'b1;
                     end
                  end
               end else begin
                  pix_col_in = pix_col_ff + 1'b1;
                  if (x_end) begin
                     cib_in  = '0;
                     bcol_in = bcol_ff + 1'b1;
                  end else begin
                     cib_in = cib_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign push_task.sum       = sum_new;
   assign push_task.span_w    = span_w;
   assign push_task.span_h    = span_h;
   assign push_task.column    = bcol_ff[COORD_W-1:0];
   assign push_task.row       = brow_ff[COORD_W-1:0];
   assign push_task.row_end   = last_col;
   assign push_task.image_end = last_col && last_row;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         state_ff   <= F_IDLE;
         pix_col_ff <= '0;
         pix_row_ff <= '0;
         cib_ff     <= '0;
         rib_ff     <= '0;
         bcol_ff    <= '0;
         brow_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         pix_col_ff <= pix_col_in;
         pix_row_ff <= pix_row_in;
         cib_ff     <= cib_in;
         rib_ff     <= rib_in;
         bcol_ff    <= bcol_in;
         brow_ff    <= brow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         grey_ff <= scaled[GREY_SHIFT+7:GREY_SHIFT];
      end
   end

   // The slot is read every cycle; it only changes when the update retires.
   always_ff @(posedge clock) begin
      rd_ff <= sums[slot];
      if (advance) begin
         sums[slot] <= sum_new;
      end
   end

endmodule

// File: hdl/gbaq_queue.sv
// Short queue of finished block sums between the front and back ends.
module gbaq_queue import gbaq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_task,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output task_type head
);

   `include "grey_block_average_quantizer_top_defines.svh"

   localparam int DEPTH = 2;

   task_type   slots_ff [DEPTH];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_task;
      end
   end

   `GBAQ_ASSERT_IMPLIES(a_no_push_when_full, push, !full || pop, "push into a full queue")
   `GBAQ_ASSERT_IMPLIES(a_no_pop_when_empty, pop, not_empty, "pop from an empty queue")
   `GBAQ_ASSERT_ALWAYS(a_count_bound, count_ff <= 2'(DEPTH), "queue count out of range")

endmodule

// File: hdl/gbaq_back.sv
// Back end: block mean through a serial divider and palette index by reciprocal multiply.
module gbaq_back import gbaq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         palette_top,
   input  logic               q_not_empty,
   input  task_type           q_head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_mean_grey,
   output logic [7:0]         rsp_palette_index,
   output logic [COORD_W-1:0] rsp_block_column,
   output logic [COORD_W-1:0] rsp_block_row,
   output logic               rsp_row_end,
   output logic               rsp_image_end
);

   `include "grey_block_average_quantizer_top_defines.svh"

   back_state_type    state_ff, state_in;
   task_type          job_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W-1:0]  divisor_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [7:0]        mean_ff;
   logic [15:0]       biased_ff;
   logic              rsp_valid_ff;
   logic              load;

   logic [CNT_W:0]   trial;
   logic             ge;
   logic [7:0]       mean;
   logic [32:0]      recip;
   logic [7:0]       palette_idx;

   assign trial       = {rem_ff, quo_ff[SUM_W-1]};
   assign ge          = trial >= {1'b0, divisor_ff};
   assign mean        = (quo_ff > SUM_W'(255)) ? 8'd255 : quo_ff[7:0];
   assign recip       = 33'(biased_ff) * 33'(IDX_RECIP);
   assign palette_idx = recip[IDX_SHIFT+7:IDX_SHIFT];

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      load     = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_not_empty) begin
               pop      = 1'b1;
               state_in = B_SIZE;
            end
         end
         B_SIZE: begin
            state_in = B_DIV;
         end
         B_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = B_SCALE;
            end
         end
         B_SCALE: begin
            state_in = B_RESULT;
         end
         B_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // One quotient bit per cycle, restoring form; this block also captures the task and forms the palette product.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_IDLE: begin
            if (pop) begin
               job_ff <= q_head;
            end
         end
         B_SIZE: begin
            divisor_ff <= CNT_W'(job_ff.span_w) * CNT_W'(job_ff.span_h);
            quo_ff     <= job_ff.sum;
            rem_ff     <= '0;
            step_ff    <= '0;
         end
         B_DIV: begin
            rem_ff  <= ge ? CNT_W'(trial - {1'b0, divisor_ff}) : trial[CNT_W-1:0];
            quo_ff  <= {quo_ff[SUM_W-2:0], ge};
            step_ff <= step_ff + 1'b1;
         end
         B_SCALE: begin
            mean_ff   <= mean;
            biased_ff <= 16'(mean) * 16'(palette_top) + 16'(IDX_BIAS);
         end
         B_RESULT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_mean_grey     <= mean_ff;
         rsp_palette_index <= palette_idx;
         rsp_block_column  <= job_ff.column;
         rsp_block_row     <= job_ff.row;
         rsp_row_end       <= job_ff.row_end;
         rsp_image_end     <= job_ff.image_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `GBAQ_ASSERT_IMPLIES(a_index_fits, state_ff == B_RESULT, recip[32:IDX_SHIFT+8] == '0, "palette index overflow")
   `GBAQ_ASSERT_IMPLIES(a_pop_only_idle, pop, state_ff == B_IDLE, "task taken while busy")

endmodule
